FILE: rtl/zwa_pkg.sv
// ----------------------------------------------------------------------------
// zwa_pkg
// Opcodes, widths and shared types of the Z-machine word ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package zwa_pkg;
    localparam int WORD_W = 16;
    localparam int OP_W = 4;
    localparam int MAX_SHIFT = 15;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [OP_W-1:0] {
        OP_INC = 4'd0, OP_DEC = 4'd1, OP_NOT = 4'd2, OP_INC_CHK = 4'd3,
        OP_DEC_CHK = 4'd4, OP_TEST = 4'd5, OP_OR = 4'd6, OP_AND = 4'd7,
        OP_ADD = 4'd8, OP_SUB = 4'd9, OP_MUL = 4'd10, OP_DIV = 4'd11,
        OP_MOD = 4'd12, OP_LSH = 4'd13, OP_ASH = 4'd14, OP_NONE = 4'd15
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [WORD_W-1:0]  a;
        logic [WORD_W-1:0]  b;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_word;
        logic store_valid;
        logic writeback_valid;
        logic branch_valid;
        logic branch_taken;
        logic divide_error;
    } res_t;
endpackage
`default_nettype wire

FILE: rtl/zmachine_word_alu.sv
// ----------------------------------------------------------------------------
// zmachine_word_alu
// Z-machine 16-bit arithmetic and logic unit on a streaming interface.
// ----------------------------------------------------------------------------
// One word in and one result word out per cycle sustained while the receiver
// keeps m_tready high. Every opcode runs through the same pipeline, whose length
// is set by the one-bit-per-stage divider.
`default_nettype none
module zmachine_word_alu import zwa_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // req_type[3:0], operand_a[19:4], operand_b[35:20]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata   // result_word[15:0], store_valid[16],
                                       // writeback_valid[17], branch_valid[18],
                                       // branch_taken[19], divide_error[20]
);
    logic f_valid, f_ready, q_valid, q_ready;
    cmd_t f_cmd, q_cmd;
    res_t res;

    zwa_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(s_tdata[3:0]), .in_a(s_tdata[19:4]), .in_b(s_tdata[35:20]),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    zwa_queue #(.DEPTH(QDEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    zwa_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {3'b000, res.divide_error, res.branch_taken, res.branch_valid,
                      res.writeback_valid, res.store_valid, res.result_word};
endmodule
`default_nettype wire

FILE: rtl/zwa_front.sv
// ----------------------------------------------------------------------------
// zwa_front
// Input register stage: takes a word and registers its opcode and operands.
// ----------------------------------------------------------------------------
`default_nettype none
module zwa_front import zwa_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [OP_W-1:0]    in_op,
    input  wire logic [WORD_W-1:0]  in_a,
    input  wire logic [WORD_W-1:0]  in_b,
    output logic                    cmd_valid,
    input  wire logic               cmd_ready,
    output cmd_t                    cmd
);
    logic valid_reg;
    cmd_t cmd_reg;

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            cmd_reg.op <= op_t'(in_op);
            cmd_reg.a  <= in_a;
            cmd_reg.b  <= in_b;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/zwa_queue.sv
// ----------------------------------------------------------------------------
// zwa_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module zwa_queue import zwa_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  cmd_t      wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output cmd_t      rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    cmd_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic wr, rd;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) mem[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

FILE: rtl/zwa_div.sv
// ----------------------------------------------------------------------------
// zwa_div
// Pipelined signed 16-bit divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module zwa_div import zwa_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [WORD_W-1:0] num,
    input  wire logic [WORD_W-1:0] den,
    output logic [WORD_W-1:0]      quo,
    output logic [WORD_W-1:0]      rem
);
    localparam int N = WORD_W;
    logic [N-1:0] q_reg [N+1];
    logic [N:0]   r_reg [N+1];
    logic [N-1:0] d_reg [N+1];
    logic         qn_reg [N+1];
    logic         rn_reg [N+1];

    always_ff @(posedge aclk) begin
        logic [N:0] sh;
        logic [N:0] df;
        if (en) begin
            q_reg[0]  <= num[N-1] ? (~num + 1'b1) : num;
            d_reg[0]  <= den[N-1] ? (~den + 1'b1) : den;
            r_reg[0]  <= '0;
            qn_reg[0] <= num[N-1] ^ den[N-1];
            rn_reg[0] <= num[N-1];
            for (int i = 0; i < N; i++) begin
                sh = {r_reg[i][N-1:0], q_reg[i][N-1]};
                df = sh - {1'b0, d_reg[i]};
                r_reg[i+1]  <= df[N] ? sh : df;
                q_reg[i+1]  <= {q_reg[i][N-2:0], ~df[N]};
                d_reg[i+1]  <= d_reg[i];
                qn_reg[i+1] <= qn_reg[i];
                rn_reg[i+1] <= rn_reg[i];
            end
        end
    end

    assign quo = qn_reg[N] ? (~q_reg[N] + 1'b1) : q_reg[N];
    assign rem = rn_reg[N] ? (~r_reg[N][N-1:0] + 1'b1) : r_reg[N][N-1:0];
endmodule
`default_nettype wire

FILE: rtl/zwa_back.sv
// ----------------------------------------------------------------------------
// zwa_back
// Execution pipeline: stage 0 splits ops, divider stages, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module zwa_back import zwa_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res
);
    localparam int LAT = WORD_W + 2;
    logic en;
    logic [LAT-1:0] v_reg;
    res_t r_reg [LAT];
    logic [1:0] dk_reg [LAT-1];
    res_t fast;
    res_t tail;
    logic [WORD_W-1:0] quo, rem;
    logic signed [WORD_W-1:0] sa, sb, inc_w, dec_w;
    logic neg;
    logic [WORD_W-1:0] shl, shr;
    logic [$clog2(WORD_W)-1:0] n;

    assign en = !v_reg[LAT-1] || res_ready;
    assign cmd_ready = en;
    assign res_valid = v_reg[LAT-1];

    assign sa = cmd.a;
    assign sb = cmd.b;
    assign inc_w = sa + 16'sd1;
    assign dec_w = sa - 16'sd1;
    assign n = $clog2(WORD_W)'(~cmd.b + 1'b1);
    assign neg = (cmd.op == OP_ASH) && cmd.a[WORD_W-1];
    assign shl = cmd.a << cmd.b[$clog2(WORD_W)-1:0];
    assign shr = neg ? WORD_W'($signed(cmd.a) >>> n) : (cmd.a >> n);

    always_comb begin
        fast = '0;
        unique case (cmd.op)
            OP_INC: begin fast.result_word = inc_w; fast.writeback_valid = 1'b1; end
            OP_DEC: begin fast.result_word = dec_w; fast.writeback_valid = 1'b1; end
            OP_NOT: begin fast.result_word = ~cmd.a; fast.store_valid = 1'b1; end
            OP_INC_CHK: begin
                fast.result_word = inc_w;
                fast.writeback_valid = 1'b1;
                fast.branch_valid = 1'b1;
                fast.branch_taken = inc_w > sb;
            end
            OP_DEC_CHK: begin
                fast.result_word = dec_w;
                fast.writeback_valid = 1'b1;
                fast.branch_valid = 1'b1;
                fast.branch_taken = dec_w < sb;
            end
            OP_TEST: begin
                fast.branch_valid = 1'b1;
                fast.branch_taken = (cmd.a & cmd.b) == cmd.b;
            end
            OP_OR:  begin fast.result_word = cmd.a | cmd.b; fast.store_valid = 1'b1; end
            OP_AND: begin fast.result_word = cmd.a & cmd.b; fast.store_valid = 1'b1; end
            OP_ADD: begin fast.result_word = cmd.a + cmd.b; fast.store_valid = 1'b1; end
            OP_SUB: begin fast.result_word = cmd.a - cmd.b; fast.store_valid = 1'b1; end
            OP_MUL: begin
                fast.result_word = WORD_W'(cmd.a * cmd.b);
                fast.store_valid = 1'b1;
            end
            OP_DIV, OP_MOD: begin
                fast.store_valid = 1'b1;
                fast.divide_error = (cmd.b == '0);
            end
            OP_LSH, OP_ASH: begin
                fast.store_valid = 1'b1;
                if (sb > $signed(WORD_W'(MAX_SHIFT)) || sb < -$signed(WORD_W'(MAX_SHIFT)))
                    fast.result_word = neg ? '1 : '0;
                else if (!cmd.b[WORD_W-1])
                    fast.result_word = shl;
                else
                    fast.result_word = shr;
            end
            default: fast = '0;
        endcase
    end

    zwa_div u_div (
        .aclk(aclk), .en(en), .num(cmd.a), .den(cmd.b), .quo(quo), .rem(rem)
    );

    always_comb begin
        tail = r_reg[LAT-2];
        if (dk_reg[LAT-2][0])
            tail.result_word = dk_reg[LAT-2][1] ? rem : quo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[LAT-2:0], cmd_valid};
        end
        if (en) begin
            r_reg[0]  <= fast;
            dk_reg[0] <= {cmd.op == OP_MOD,
                          (cmd.op == OP_DIV || cmd.op == OP_MOD) && cmd.b != '0};
            for (int i = 1; i < LAT - 1; i++) begin
                r_reg[i]  <= r_reg[i-1];
                dk_reg[i] <= dk_reg[i-1];
            end
            r_reg[LAT-1] <= tail;
        end
    end
    assign res = r_reg[LAT-1];

`ifndef SYNTHESIS
    a_err_store: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.divide_error |-> res.store_valid && res.result_word == '0)
        else $error("divide error without store or zero value");
    a_taken_bv: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.branch_taken |-> res.branch_valid)
        else $error("branch taken without branch form");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("stalled result changed");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !(res.store_valid && res.writeback_valid))
        else $error("store and write-back together");
`endif
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Z-machine word ALU: directed opcode corners,
// then random bursts with receiver stalls and a held-off receiver, checked against a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module testbench;
    import zwa_pkg::*;

    localparam int LATENCY = 20;
    localparam int CYCLE_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [39:0] s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [23:0] m_tdata;

    res_t expected_words[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   hold_cycles = 0;
    bit   stall_enable = 1'b1;

    zmachine_word_alu uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [15:0] shift_word(logic [15:0] a, logic [15:0] cnt, bit arith);
        logic neg;
        int   places;
        neg = arith && a[15];
        places = $signed(cnt);
        if (places < -MAX_SHIFT || places > MAX_SHIFT) return neg ? 16'hFFFF : 16'h0;
        if (places >= 0) return a << places;
        return arith ? 16'($signed(a) >>> (-places)) : a >> (-places);
    endfunction

    function automatic res_t alu_predict(op_t op, logic [15:0] a, logic [15:0] b);
        res_t r;
        logic signed [16:0] sa, sb, q;
        r = '0;
        sa = $signed({a[15], a});
        sb = $signed({b[15], b});
        case (op)
            OP_INC: begin r.result_word = a + 16'd1; r.writeback_valid = 1'b1; end
            OP_DEC: begin r.result_word = a - 16'd1; r.writeback_valid = 1'b1; end
            OP_NOT: begin r.result_word = ~a; r.store_valid = 1'b1; end
            OP_INC_CHK: begin
                r.result_word = a + 16'd1; r.writeback_valid = 1'b1; r.branch_valid = 1'b1;
                r.branch_taken = $signed(r.result_word) > $signed(b);
            end
            OP_DEC_CHK: begin
                r.result_word = a - 16'd1; r.writeback_valid = 1'b1; r.branch_valid = 1'b1;
                r.branch_taken = $signed(r.result_word) < $signed(b);
            end
            OP_TEST: begin r.branch_valid = 1'b1; r.branch_taken = (a & b) == b; end
            OP_OR:  begin r.result_word = a | b; r.store_valid = 1'b1; end
            OP_AND: begin r.result_word = a & b; r.store_valid = 1'b1; end
            OP_ADD: begin r.result_word = a + b; r.store_valid = 1'b1; end
            OP_SUB: begin r.result_word = a - b; r.store_valid = 1'b1; end
            OP_MUL: begin r.result_word = a * b; r.store_valid = 1'b1; end
            OP_DIV, OP_MOD: begin
                r.store_valid = 1'b1;
                if (b == 16'd0) r.divide_error = 1'b1;
                else begin
                    q = (op == OP_DIV) ? sa / sb : sa % sb;
                    r.result_word = q[15:0];
                end
            end
            OP_LSH: begin r.result_word = shift_word(a, b, 1'b0); r.store_valid = 1'b1; end
            OP_ASH: begin r.result_word = shift_word(a, b, 1'b1); r.store_valid = 1'b1; end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic send_word(op_t op, logic [15:0] a, logic [15:0] b);
        expected_words.push_back(alu_predict(op, a, b));
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, b, a, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_line();
        s_tvalid <= 1'b0;
    endtask

    task automatic random_gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (n > 0) begin
            idle_line();
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        idle_line();
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] corner_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'($urandom_range(0, 40)) - 16'd20;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_word(OP_INC, 16'hFFFF, 16'h0000);
        send_word(OP_INC, 16'h7FFF, 16'hFFFF);
        send_word(OP_DEC, 16'h0000, 16'h0000);
        send_word(OP_NOT, 16'h5A5A, 16'h0000);
        send_word(OP_INC_CHK, 16'h7FFF, 16'h0000);
        send_word(OP_INC_CHK, 16'h0004, 16'h0004);
        send_word(OP_DEC_CHK, 16'h8000, 16'h0000);
        send_word(OP_DEC_CHK, 16'h0000, 16'h0000);
        send_word(OP_TEST, 16'hFFFF, 16'hF0F0);
        send_word(OP_TEST, 16'h0F0F, 16'hF0F0);
        send_word(OP_OR, 16'hFF00, 16'h00FF);
        send_word(OP_AND, 16'hFFFF, 16'hFFFF);
        send_word(OP_ADD, 16'hFFFF, 16'h0001);
        send_word(OP_SUB, 16'h0000, 16'h0001);
        send_word(OP_MUL, 16'hFFFF, 16'hFFFF);
        send_word(OP_DIV, 16'hFFF9, 16'h0002);
        send_word(OP_DIV, 16'h1234, 16'h0000);
        send_word(OP_MOD, 16'h1234, 16'h0000);
        send_word(OP_DIV, 16'h8000, 16'hFFFF);
        send_word(OP_MOD, 16'h8000, 16'hFFFF);
        send_word(OP_LSH, 16'hFFFF, 16'd16);
        send_word(OP_ASH, 16'h8001, 16'hFFF0);
        send_word(OP_ASH, 16'h8001, 16'hFFF1);
        send_word(OP_LSH, 16'h8001, 16'hFFF1);
        send_word(OP_ASH, 16'hC003, 16'd15);
        send_word(OP_NONE, 16'hFFFF, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_random(int count);
        op_t op;
        for (int i = 0; i < count; i++) begin
            op = op_t'($urandom_range(0, 15));
            send_word(op, corner_word(),
                      (op == OP_LSH || op == OP_ASH) && $urandom_range(0, 1)
                          ? 16'($urandom_range(0, 40)) - 16'd20 : corner_word());
            random_gap();
        end
        idle_line();
    endtask

    task automatic test_backpressure();
        stall_enable = 1'b0;
        hold_cycles = 60;
        for (int i = 0; i < 40; i++)
            send_word(op_t'($urandom_range(0, 15)), 16'($urandom), 16'($urandom));
        idle_line();
        stall_enable = 1'b1;
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (!aresetn || !stall_enable) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= (cycles % 97 < 50) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.result_word     = m_tdata[15:0];
            got.store_valid     = m_tdata[16];
            got.writeback_valid = m_tdata[17];
            got.branch_valid    = m_tdata[18];
            got.branch_taken    = m_tdata[19];
            got.divide_error    = m_tdata[20];
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
            end else begin
                want = expected_words.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b%b%b%b%b actual %h/%b%b%b%b%b",
                            want.result_word, want.store_valid, want.writeback_valid,
                            want.branch_valid, want.branch_taken, want.divide_error,
                            got.result_word, got.store_valid, got.writeback_valid,
                            got.branch_valid, got.branch_taken, got.divide_error);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(200);
        test_backpressure();
        test_random(200);
        wait_drained();
        repeat (LATENCY * 2) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

FILE: zmachine_word_alu.f
rtl/zwa_pkg.sv
rtl/zwa_front.sv
rtl/zwa_queue.sv
rtl/zwa_div.sv
rtl/zwa_back.sv
rtl/zmachine_word_alu.sv
tb/testbench.sv
